[design/ppfa_pkg.sv]
// Shared types, constants and codes of the per-CPU page free-list allocator.
`default_nettype none

package ppfa_pkg;

    // Default sizing of the top level
    localparam int CPU_COUNT_DEF  = 8;
    localparam int PAGE_COUNT_DEF = 32768;
    localparam int PAGE_SHIFT_DEF = 12;

    // Fixed field widths
    localparam int ADDR_W      = 34;
    localparam int CPU_FIELD_W = 3;
    localparam int STATUS_W    = 2;
    localparam int ALU_W       = ADDR_W + 1;
    localparam int CFG_IDX_W   = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_LIMIT = 2'd1;

    localparam logic [ADDR_W-1:0] LOW_LIMIT_RST = 34'h0_8000_0000;
    localparam logic [ADDR_W-1:0] TOP_LIMIT_RST = 34'h0_8800_0000;

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;

    typedef struct packed {
        logic                   req_type;
        logic [CPU_FIELD_W-1:0] cpu;
        logic [ADDR_W-1:0]      page_addr;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   alloc_addr;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    // Operation handed to the shared adder
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    // carry is set on a subtract when a >= b
    typedef struct packed {
        logic             carry;
        logic [ALU_W-1:0] sum;
    } alu_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_F_LOW,
        ST_F_TOP,
        ST_F_BASE,
        ST_F_IDX,
        ST_F_PUSH,
        ST_A_HEAD,
        ST_A_LINK,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

[design/ppfa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ppfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                              clk,
    input  wire logic                              we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                  wdata,
    input  wire logic                              re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/ppfa_alu.sv]
// Shared adder/subtractor used by every address step of the sequencer.
`default_nettype none

module ppfa_alu
    import ppfa_pkg::*;
(
    input  wire alu_req_t op,
    output alu_rsp_t      res
);

    logic [ALU_W:0] total;

    always_comb
    begin
        if (op.sub)
        begin
            total = {1'b0, op.a} + {1'b0, ~op.b} + {{ALU_W{1'b0}}, 1'b1};
        end
        else
        begin
            total = {1'b0, op.a} + {1'b0, op.b};
        end
        res.carry = total[ALU_W];
        res.sum   = total[ALU_W-1:0];
    end

endmodule

`default_nettype wire

[design/ppfa_pick.sv]
// List selection: own CPU list for a free or when it is non-empty, else lowest-numbered other non-empty list.
`default_nettype none

module ppfa_pick
    import ppfa_pkg::*;
#(
    parameter int CPU_COUNT = CPU_COUNT_DEF
) (
    input  wire logic                   req_type,
    input  wire logic [CPU_FIELD_W-1:0] cpu,
    input  wire logic [CPU_COUNT-1:0]   head_valid,
    output logic [((CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1)-1:0] sel,
    output logic                        got
);

    localparam int CPU_W = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

    logic [CPU_W-1:0] own;
    logic [CPU_W-1:0] steal;
    logic             found;

    always_comb
    begin
        own = '0;
        // cpu mod CPU_COUNT as a small constant table
        for (int i = 0; i < (1 << CPU_FIELD_W); i++)
        begin
            if (cpu == CPU_FIELD_W'(i))
            begin
                own = CPU_W'(i % CPU_COUNT);
            end
        end

        steal = '0;
        found = 1'b0;
        // scan downwards so the lowest index wins
        for (int i = CPU_COUNT - 1; i >= 0; i--)
        begin
            if (head_valid[i] && (CPU_W'(i) != own))
            begin
                steal = CPU_W'(i);
                found = 1'b1;
            end
        end

        if (req_type == REQ_FREE || head_valid[own])
        begin
            sel = own;
            got = head_valid[own];
        end
        else
        begin
            sel = steal;
            got = found;
        end
    end

endmodule

`default_nettype wire

[design/per_cpu_page_free_list_allocator_core.sv]
// Top level: per-CPU LIFO page free lists with stealing, run by a small sequencer.
//
//  channel  | valid      | stall      | payload   | notes
//  ---------+------------+------------+-----------+-------------------------------
//  request  | req_valid  | req_stall  | req       | allocate or free, one at a time
//  result   | rsp_valid  | rsp_stall  | rsp       | one result per request, in order
//  config   | cfg_we     | -          | cfg_data  | cfg_index 0 low, 1 top limit
//
// Free steps: low limit, top limit, base, index, push; a limit reject or a page
// beyond capacity ends it early. Allocate steps: head read, base and link read,
// address; all lists empty goes straight to the result. Steps follow from the
// one shared adder (limit checks, base, index, address) and registered RAM reads.
// Reset empties every list at once through per-CPU valid bits; no clearing pass.
// The result register frees the sequencer: a new request is taken while a result
// waits; a stalled result holds the sequencer only in its final step.
`default_nettype none

module per_cpu_page_free_list_allocator_core
    import ppfa_pkg::*;
#(
    parameter int CPU_COUNT  = CPU_COUNT_DEF,
    parameter int PAGE_COUNT = PAGE_COUNT_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire req_t                 req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output rsp_t                      rsp,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ADDR_W-1:0]    cfg_data
);

    localparam int CPU_W  = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int IDX_W  = $clog2(PAGE_COUNT);
    localparam int LINK_W = IDX_W + 1;
    localparam int OFF_W  = IDX_W + PAGE_SHIFT;
    localparam logic [ALU_W-1:0] OFF_MASK = ALU_W'((64'd1 << PAGE_SHIFT) - 64'd1);

    state_t              state_reg, state_next;
    req_t                item_reg, item_next;
    logic [CPU_W-1:0]    sel_reg, sel_next;
    logic                reject_reg, reject_next;
    logic [ALU_W-1:0]    base_reg, base_next;
    logic [IDX_W-1:0]    page_reg, page_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;
    logic [CPU_COUNT-1:0] head_valid_reg, head_valid_next;
    logic [ADDR_W-1:0]   low_reg, low_next;
    logic [ADDR_W-1:0]   top_reg, top_next;

    logic                head_we, head_re;
    logic [CPU_W-1:0]    head_waddr, head_raddr;
    logic [IDX_W-1:0]    head_wdata, head_rdata;
    logic                link_we, link_re;
    logic [IDX_W-1:0]    link_waddr, link_raddr;
    logic [LINK_W-1:0]   link_wdata, link_rdata;

    alu_req_t            alu_op;
    alu_rsp_t            alu_res;

    logic [CPU_W-1:0]    pick_sel;
    logic                pick_got;
    logic                misaligned;
    logic [ALU_W-1:0]    quot;
    logic [OFF_W-1:0]    page_off;

    ppfa_alu u_alu (
        .op  (alu_op),
        .res (alu_res)
    );

    ppfa_pick #(
        .CPU_COUNT (CPU_COUNT)
    ) u_pick (
        .req_type   (req.req_type),
        .cpu        (req.cpu),
        .head_valid (head_valid_reg),
        .sel        (pick_sel),
        .got        (pick_got)
    );

    ppfa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (CPU_COUNT)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .re    (head_re),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    ppfa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (PAGE_COUNT)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    assign misaligned = |item_reg.page_addr[PAGE_SHIFT-1:0];
    assign quot       = alu_res.sum >> PAGE_SHIFT;
    assign page_off   = OFF_W'(head_rdata) << PAGE_SHIFT;

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Configuration writes
    always_comb
    begin
        low_next = low_reg;
        top_next = top_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOW_LIMIT: low_next = cfg_data;
                CFG_TOP_LIMIT: top_next = cfg_data;
                default:       ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        sel_next        = sel_reg;
        reject_next     = reject_reg;
        base_next       = base_reg;
        page_next       = page_reg;
        res_addr_next   = res_addr_reg;
        status_next     = status_reg;
        head_valid_next = head_valid_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;

        alu_op     = '0;
        head_we    = 1'b0;
        head_waddr = sel_reg;
        head_wdata = page_reg;
        head_re    = 1'b0;
        head_raddr = pick_sel;
        link_we    = 1'b0;
        link_waddr = page_reg;
        link_wdata = {head_valid_reg[sel_reg], head_rdata};
        link_re    = 1'b0;
        link_raddr = head_rdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next     = req;
                    sel_next      = pick_sel;
                    res_addr_next = '0;
                    status_next   = STATUS_OK;
                    head_re       = 1'b1;
                    if (req.req_type == REQ_FREE)
                    begin
                        state_next = ST_F_LOW;
                    end
                    else if (pick_got)
                    begin
                        state_next = ST_A_HEAD;
                    end
                    else
                    begin
                        status_next = STATUS_EMPTY;
                        state_next  = ST_DONE;
                    end
                end
            end

            ST_F_LOW:
            begin
                alu_op.a    = ALU_W'(item_reg.page_addr);
                alu_op.b    = ALU_W'(low_reg);
                alu_op.sub  = 1'b1;
                reject_next = misaligned || !alu_res.carry;
                state_next  = ST_F_TOP;
            end

            ST_F_TOP:
            begin
                alu_op.a   = ALU_W'(item_reg.page_addr);
                alu_op.b   = ALU_W'(top_reg);
                alu_op.sub = 1'b1;
                if (reject_reg || alu_res.carry)
                begin
                    status_next = STATUS_REJECT;
                    state_next  = ST_DONE;
                end
                else
                begin
                    state_next = ST_F_BASE;
                end
            end

            ST_F_BASE:
            begin
                alu_op.a   = ALU_W'(low_reg);
                alu_op.b   = OFF_MASK;
                base_next  = alu_res.sum & ~OFF_MASK;
                state_next = ST_F_IDX;
            end

            ST_F_IDX:
            begin
                alu_op.a   = ALU_W'(item_reg.page_addr);
                alu_op.b   = base_reg;
                alu_op.sub = 1'b1;
                page_next  = quot[IDX_W-1:0];
                if (quot < ALU_W'(PAGE_COUNT))
                begin
                    state_next = ST_F_PUSH;
                end
                else
                begin
                    status_next = STATUS_REJECT;
                    state_next  = ST_DONE;
                end
            end

            ST_F_PUSH:
            begin
                // old head goes behind the freed page
                link_we                  = 1'b1;
                head_we                  = 1'b1;
                head_valid_next[sel_reg] = 1'b1;
                state_next               = ST_DONE;
            end

            ST_A_HEAD:
            begin
                alu_op.a   = ALU_W'(low_reg);
                alu_op.b   = OFF_MASK;
                base_next  = alu_res.sum & ~OFF_MASK;
                link_re    = 1'b1;
                state_next = ST_A_LINK;
            end

            ST_A_LINK:
            begin
                alu_op.a      = base_reg;
                alu_op.b      = ALU_W'(page_off);
                res_addr_next = alu_res.sum[ADDR_W-1:0];
                if (link_rdata[IDX_W])
                begin
                    head_we    = 1'b1;
                    head_wdata = link_rdata[IDX_W-1:0];
                end
                else
                begin
                    head_valid_next[sel_reg] = 1'b0;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.alloc_addr = res_addr_reg;
                    rsp_next.status     = status_reg;
                    rsp_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rsp_valid_reg  <= 1'b0;
            head_valid_reg <= '0;
            low_reg        <= LOW_LIMIT_RST;
            top_reg        <= TOP_LIMIT_RST;
        end
        else
        begin
            state_reg      <= state_next;
            rsp_valid_reg  <= rsp_valid_next;
            head_valid_reg <= head_valid_next;
            low_reg        <= low_next;
            top_reg        <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        sel_reg      <= sel_next;
        reject_reg   <= reject_next;
        base_reg     <= base_next;
        page_reg     <= page_next;
        res_addr_reg <= res_addr_next;
        status_reg   <= status_next;
        rsp_reg      <= rsp_next;
    end

    // A fresh result comes only from the final step
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!rsp_valid_reg || !rsp_stall) && state_reg != ST_DONE |=> !$rose(rsp_valid_reg))
        else $error("result raised outside the final step");

    // An accepted item always starts the sequence
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg != ST_IDLE)
        else $error("accepted item did not start the sequence");

    // A pop only ever runs on a non-empty list
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_A_HEAD || state_reg == ST_A_LINK |-> head_valid_reg[sel_reg])
        else $error("pop from an empty list");

    // Results carry only defined status codes, and no address unless allocated
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status != STATUS_OK |-> rsp_reg.alloc_addr == '0 &&
        (rsp_reg.status == STATUS_REJECT || rsp_reg.status == STATUS_EMPTY))
        else $error("bad status or stray address in result");

endmodule

`default_nettype wire
